>>> hdl/tfcd_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the crc byte update for the timing frame checker
// no dependencies

package tfcd_pkg;

    localparam int unsigned FRAME_BYTES = 56;
    localparam int unsigned CRC_SPAN    = 52;
    localparam int unsigned AUTH_OFFSET = 48;
    localparam int unsigned FIELD_FIRST = 8;
    localparam int unsigned LEN_FIRST   = 6;
    localparam int unsigned COUNT_MAX   = 57;
    localparam int unsigned NUM_FIELDS  = 5;
    localparam int unsigned FIELD_W     = 64;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned OUT_BITS    = 1 + STATUS_W + NUM_FIELDS * FIELD_W + 1;
    localparam int unsigned OUT_W       = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [7:0]  VERSION  = 8'h01;
    localparam logic [7:0]  FRAME_TYPE = 8'h01;
    localparam logic [15:0] LEN_EXPECT = 16'd56;

    localparam logic [7:0] MAGIC [4] = '{8'h53, 8'h46, 8'h4C, 8'h45};

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_SIZE      = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_VERSION   = 3'd3,
        ST_TYPE      = 3'd4,
        ST_LENGTH    = 3'd5,
        ST_CRC       = 3'd6,
        ST_ZERO_FLD  = 3'd7
    } status_t;

    typedef logic [FIELD_W-1:0] field_t;

    // reflected crc-32, one byte, lsb first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> hdl/timing_frame_checker_decoder.sv
`timescale 1ns / 1ps
// timing frame checker and decoder: byte stream in, one decoded result per frame
// depends on tfcd_pkg
//
// usage
//   s_* channel carries the frame one byte per transfer from offset zero,
//   s_tlast marks the final byte. each frame gives exactly one result
//   transfer on the m_* channel: frame_ok, status code, five 64-bit fields
//   and the authenticated bit (fields read as zero unless status is ok).
//   status picks the first failing check: size, magic, version, type,
//   length field, crc, zero field.
// timing
//   a byte is held in the input register, then is folded into the
//   frame state; the result is registered, so m_tvalid rises at the edge
//   where the final byte leaves the input register. one byte per cycle
//   sustained unless a final byte waits for the output register: the crc
//   byte update and the header checks are combinational.
// reset
//   rst_n clears the input and output valid flags, the byte counter, the
//   crc register to its initial value and the first error code; no frame is in progress.
// backpressure
//   while a result waits on m_tready, bytes that are not the final byte of
//   the next frame keep flowing; a final byte waits in the input register
//   until the output register is free, and s_tready drops behind it.

module timing_frame_checker_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    // input byte stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // [7:0] data_byte
    input  logic                         s_tlast,  // last_byte
    // decoded result
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] frame_ok, [3:1] status, [67:4] node_id, [131:68] sequence_res,
    // [195:132] epoch_num, [259:196] evt_count,
    // [323:260] transmit_time_ns, [324] authenticated, [327:325] zero
    output logic [tfcd_pkg::OUT_W-1:0]   m_tdata
);

    localparam int unsigned CW = tfcd_pkg::COUNT_W;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // frame state
    logic [CW-1:0]          byte_count_reg, byte_count_next;
    logic [31:0]            crc_reg, crc_next;
    tfcd_pkg::status_t      first_err_reg, first_err_next;
    logic [31:0]            rx_crc_reg, rx_crc_next;
    logic [15:0]            len_reg, len_next;
    tfcd_pkg::field_t       field_reg [tfcd_pkg::NUM_FIELDS];
    tfcd_pkg::field_t       field_next [tfcd_pkg::NUM_FIELDS];
    logic                   auth_reg, auth_next;

    // result register
    logic                   out_valid_reg;
    logic [tfcd_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    logic                   out_free;
    logic                   advance;
    logic                   take;
    logic [CW-1:0]          pos;
    logic [CW-1:0]          rel;
    tfcd_pkg::status_t      status;
    logic                   any_zero;

    assign out_free = !out_valid_reg || m_tready;
    // the held byte moves on unless it ends a frame and the result slot is busy
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // per-byte state update and end-of-frame verdict
    always_comb
    begin
        pos  = byte_count_reg;
        take = (pos < CW'(tfcd_pkg::FRAME_BYTES));
        rel  = pos - CW'(tfcd_pkg::FIELD_FIRST);

        byte_count_next = (pos < CW'(tfcd_pkg::COUNT_MAX)) ? pos + CW'(1) : pos;
        crc_next        = crc_reg;
        first_err_next  = first_err_reg;
        rx_crc_next     = rx_crc_reg;
        len_next        = len_reg;
        auth_next       = auth_reg;
        for (int k = 0; k < tfcd_pkg::NUM_FIELDS; k++)
            field_next[k] = field_reg[k];

        if (pos < CW'(tfcd_pkg::CRC_SPAN))
            crc_next = tfcd_pkg::crc32_byte(crc_reg, in_byte_reg);

        if (take)
        begin
            if (pos < CW'(4))
            begin
                if (in_byte_reg != tfcd_pkg::MAGIC[pos[1:0]] &&
                    first_err_reg == tfcd_pkg::ST_OK)
                    first_err_next = tfcd_pkg::ST_MAGIC;
            end
            else if (pos == CW'(4))
            begin
                if (in_byte_reg != tfcd_pkg::VERSION && first_err_reg == tfcd_pkg::ST_OK)
                    first_err_next = tfcd_pkg::ST_VERSION;
            end
            else if (pos == CW'(5))
            begin
                if (in_byte_reg != tfcd_pkg::FRAME_TYPE &&
                    first_err_reg == tfcd_pkg::ST_OK)
                    first_err_next = tfcd_pkg::ST_TYPE;
            end
            else if (pos < CW'(tfcd_pkg::FIELD_FIRST))
            begin
                if (pos[0])
                    len_next[15:8] = in_byte_reg;
                else
                    len_next[7:0] = in_byte_reg;
            end
            else if (pos < CW'(tfcd_pkg::AUTH_OFFSET))
            begin
                for (int k = 0; k < tfcd_pkg::NUM_FIELDS; k++)
                    if (rel[5:3] == 3'(k))
                        field_next[k][rel[2:0]*8 +: 8] = in_byte_reg;
            end
            else if (pos == CW'(tfcd_pkg::AUTH_OFFSET))
                auth_next = in_byte_reg[0];
            else if (pos >= CW'(tfcd_pkg::CRC_SPAN))
                rx_crc_next[pos[1:0]*8 +: 8] = in_byte_reg;
        end

        any_zero = 1'b0;
        for (int k = 0; k < tfcd_pkg::NUM_FIELDS; k++)
            if (field_next[k] == '0)
                any_zero = 1'b1;

        if (byte_count_next != CW'(tfcd_pkg::FRAME_BYTES))
            status = tfcd_pkg::ST_SIZE;
        else if (first_err_next != tfcd_pkg::ST_OK)
            status = first_err_next;
        else if (len_next != tfcd_pkg::LEN_EXPECT)
            status = tfcd_pkg::ST_LENGTH;
        else if ((crc_next ^ tfcd_pkg::CRC_INIT) != rx_crc_next)
            status = tfcd_pkg::ST_CRC;
        else if (any_zero)
            status = tfcd_pkg::ST_ZERO_FLD;
        else
            status = tfcd_pkg::ST_OK;

        out_data_next = '0;
        out_data_next[0]   = (status == tfcd_pkg::ST_OK);
        out_data_next[3:1] = status;
        if (status == tfcd_pkg::ST_OK)
        begin
            for (int k = 0; k < tfcd_pkg::NUM_FIELDS; k++)
                out_data_next[4 + k*tfcd_pkg::FIELD_W +: tfcd_pkg::FIELD_W] = field_next[k];
            out_data_next[4 + tfcd_pkg::NUM_FIELDS*tfcd_pkg::FIELD_W] = auth_next;
        end
    end

    // control part of the frame state; a final byte returns it to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= tfcd_pkg::CRC_INIT;
            first_err_reg  <= tfcd_pkg::ST_OK;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                byte_count_reg <= '0;
                crc_reg        <= tfcd_pkg::CRC_INIT;
                first_err_reg  <= tfcd_pkg::ST_OK;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                crc_reg        <= crc_next;
                first_err_reg  <= first_err_next;
            end
        end
    end

    // payload captures: every slot is rewritten before a full-size frame reads it
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rx_crc_reg <= rx_crc_next;
            len_reg    <= len_next;
            auth_reg   <= auth_next;
            for (int k = 0; k < tfcd_pkg::NUM_FIELDS; k++)
                field_reg[k] <= field_next[k];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance && in_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks

    a_ok_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == tfcd_pkg::ST_OK)))
        else $error("frame_ok disagrees with status");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[tfcd_pkg::OUT_W-1:4] == '0))
        else $error("fields not cleared on a failed frame");

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> m_tvalid)
        else $error("final byte did not produce a result");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CW'(tfcd_pkg::COUNT_MAX))
        else $error("byte counter past saturation");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (byte_count_reg == '0 &&
                                      first_err_reg == tfcd_pkg::ST_OK))
        else $error("frame state not cleared after final byte");

endmodule
